### sv/fdmr_pkg.sv
package fdmr_pkg;

    // Register offsets decoded while the newer register set is mapped.
    localparam logic [3:0] OFF_PARAM_WR = 4'd3;
    localparam logic [3:0] OFF_PHASE_WR = 4'd4;
    localparam logic [3:0] OFF_MODE0    = 4'd6;
    localparam logic [3:0] OFF_MODE1    = 4'd7;
    localparam logic [3:0] OFF_PARAM_RD = 4'd11;
    localparam logic [3:0] OFF_PHASE_RD = 4'd12;
    localparam logic [3:0] OFF_STATUS   = 4'd14;
    localparam logic [3:0] OFF_SENSE    = 4'd15;

    // Legacy register numbers formed from the latch bits.
    localparam logic [2:0] LEG_SEL_ALL_ONES = 3'd0;
    localparam logic [2:0] LEG_SEL_SET_MODE = 3'd6;

    localparam int unsigned MODE_BIT = 6;

    localparam logic [7:0] MODE_BIT_MASK  = 8'h40;
    localparam logic [7:0] SENSE_PHASE    = 8'h77;
    localparam logic [7:0] SENSE_ANSWER   = 8'h08;
    localparam logic [7:0] ALL_ONES_VALUE = 8'hff;

    localparam int unsigned PARAM_DEPTH = 16;
    localparam int unsigned PARAM_IDX_W = $clog2(PARAM_DEPTH);

    // Steps of the mode switch sequence on bit 6: 1, 0, 1, 1.
    typedef enum logic [1:0] {
        SW_WAIT_ONE_A = 2'd0,
        SW_WAIT_ZERO  = 2'd1,
        SW_WAIT_ONE_B = 2'd2,
        SW_WAIT_ONE_C = 2'd3
    } t_switch_step;

    typedef struct packed {
        logic step;
    } t_dp_cmd;

    typedef struct packed {
        logic new_mode;
    } t_dp_stat;

endpackage

### sv/fdmr_ctrl.sv
module fdmr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output fdmr_pkg::t_dp_cmd o_cmd,
    input  fdmr_pkg::t_dp_stat i_stat
);
    import fdmr_pkg::*;

    typedef enum logic {
        ST_EMPTY,
        ST_FULL
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   step;

    // A new word may enter whenever the output register is empty or is being taken.
    assign o_ready    = (r_state == ST_EMPTY) || i_ready;
    assign step       = i_valid && o_ready;
    assign o_cmd.step = step;
    assign o_valid    = (r_state == ST_FULL);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_EMPTY: begin
                if (step) begin
                    n_state = ST_FULL;
                end
            end
            ST_FULL: begin
                if (i_ready && !step) begin
                    n_state = ST_EMPTY;
                end
            end
            default: n_state = ST_EMPTY;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

    a_step_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> o_valid)
        else $error("accepted word did not produce a result");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("empty output register refused a word");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !i_valid) |=> !o_valid)
        else $error("result delivered twice");

    // Status is only observed to check that the mode bit is known while a result is held.
    a_stat_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !$isunknown(i_stat.new_mode))
        else $error("mode status unknown while result held");

endmodule

### sv/fdmr_dp.sv
module fdmr_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fdmr_pkg::t_dp_cmd  i_cmd,
    output fdmr_pkg::t_dp_stat o_stat,
    input  logic               i_action,
    input  logic [3:0]         i_reg_offset,
    input  logic [7:0]         i_write_data,
    output logic [7:0]         o_rd_byte,
    output logic               o_new_mode_active
);
    import fdmr_pkg::*;

    logic                   r_active;
    logic                   n_active;
    t_switch_step           r_switch;
    t_switch_step           n_switch;
    logic [7:0]             r_latch;
    logic [7:0]             n_latch;
    logic [7:0]             r_phase;
    logic [7:0]             n_phase;
    logic [7:0]             r_mode_reg;
    logic [7:0]             n_mode_reg;
    logic [PARAM_IDX_W-1:0] r_param_idx;
    logic [PARAM_IDX_W-1:0] n_param_idx;
    logic [7:0]             r_param [PARAM_DEPTH];
    logic                   param_we;
    logic [7:0]             r_rd_byte;
    logic [7:0]             n_rd_byte;
    logic                   r_out_mode;

    logic [7:0] sel_latch;
    logic [2:0] leg_sel;
    logic       bit6;
    logic [7:0] mode_cleared;

    always_comb begin
        // Legacy access: offset bits 3..1 pick a latch, bit 0 is its value.
        sel_latch = r_latch;
        sel_latch[i_reg_offset[3:1]] = i_reg_offset[0];
        leg_sel      = {sel_latch[7], sel_latch[6], sel_latch[4]};
        bit6         = i_write_data[MODE_BIT];
        mode_cleared = r_mode_reg & ~i_write_data;

        n_active    = r_active;
        n_switch    = r_switch;
        n_latch     = r_latch;
        n_phase     = r_phase;
        n_mode_reg  = r_mode_reg;
        n_param_idx = r_param_idx;
        n_rd_byte   = '0;
        param_we    = 1'b0;

        if (!r_active) begin
            n_latch = sel_latch;
            if (!i_action) begin
                n_rd_byte = (leg_sel == LEG_SEL_ALL_ONES) ? ALL_ONES_VALUE : 8'h00;
            end else if (leg_sel == LEG_SEL_SET_MODE) begin
                unique case (r_switch)
                    SW_WAIT_ONE_A: if (bit6) n_switch = SW_WAIT_ZERO;
                    SW_WAIT_ZERO:  if (!bit6) n_switch = SW_WAIT_ONE_B;
                    SW_WAIT_ONE_B: if (bit6) n_switch = SW_WAIT_ONE_C;
                    SW_WAIT_ONE_C: begin
                        if (bit6) begin
                            n_active   = 1'b1;
                            n_mode_reg = r_mode_reg | MODE_BIT_MASK;
                            n_switch   = SW_WAIT_ONE_A;
                        end
                    end
                    default: n_switch = SW_WAIT_ONE_A;
                endcase
            end
        end else if (i_action) begin
            unique case (i_reg_offset)
                OFF_PARAM_WR: begin
                    param_we    = 1'b1;
                    n_param_idx = r_param_idx + 1'b1;
                end
                OFF_PHASE_WR: n_phase = i_write_data;
                OFF_MODE0: begin
                    n_mode_reg  = mode_cleared;
                    n_param_idx = '0;
                    if (!mode_cleared[MODE_BIT]) begin
                        n_active = 1'b0;
                        n_latch  = '0;
                    end
                end
                OFF_MODE1: n_mode_reg = r_mode_reg | i_write_data;
                default: ;
            endcase
        end else begin
            unique case (i_reg_offset)
                OFF_PARAM_RD: begin
                    n_rd_byte   = r_param[r_param_idx];
                    n_param_idx = r_param_idx + 1'b1;
                end
                OFF_PHASE_RD: n_rd_byte = r_phase;
                OFF_STATUS:   n_rd_byte = MODE_BIT_MASK;
                OFF_SENSE:    n_rd_byte = (r_phase == SENSE_PHASE) ? SENSE_ANSWER : 8'h00;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_switch    <= SW_WAIT_ONE_A;
            r_latch     <= '0;
            r_phase     <= '0;
            r_mode_reg  <= '0;
            r_param_idx <= '0;
            for (int i = 0; i < PARAM_DEPTH; i++) begin
                r_param[i] <= '0;
            end
        end else if (i_cmd.step) begin
            r_active    <= n_active;
            r_switch    <= n_switch;
            r_latch     <= n_latch;
            r_phase     <= n_phase;
            r_mode_reg  <= n_mode_reg;
            r_param_idx <= n_param_idx;
            if (param_we) begin
                r_param[r_param_idx] <= i_write_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_rd_byte  <= n_rd_byte;
            r_out_mode <= n_active;
        end
    end

    assign o_rd_byte         = r_rd_byte;
    assign o_new_mode_active = r_out_mode;
    assign o_stat.new_mode   = r_active;

    a_mode0_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && r_active && i_action && i_reg_offset == OFF_MODE0)
        |=> (r_param_idx == '0))
        else $error("MODE0 write did not rewind the parameter index");

    a_legacy_bit_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> !r_mode_reg[MODE_BIT])
        else $error("legacy mode with mode bit set");

    a_out_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |=> (o_new_mode_active == r_active))
        else $error("reported mode differs from stored mode");

    a_legacy_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && !r_active && !i_action)
        |=> (o_rd_byte == ALL_ONES_VALUE || o_rd_byte == 8'h00))
        else $error("legacy read returned an odd value");

endmodule

### sv/floppy_ctrl_dual_mode_registers_top.sv
// Channel   Handshake            Payload
// in        i_valid / o_ready    i_action, i_reg_offset, i_write_data
// out       o_valid / i_ready    o_rd_byte, o_new_mode_active
//
// Each word is decoded and its register update applied on acceptance; its
// result is registered, and one word per cycle is sustained while taken.
// A word is taken while the held result is being accepted in the same cycle.
// Synchronous active-low reset clears the mode, switch, latch, phase and index
// state and the 16-byte parameter store, but not the output register.
// A stalled output holds its result and blocks new words until it is taken.
module floppy_ctrl_dual_mode_registers_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_action,
    input  logic [3:0] i_reg_offset,
    input  logic [7:0] i_write_data,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_rd_byte,
    output logic       o_new_mode_active
);
    import fdmr_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    fdmr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    fdmr_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_action          (i_action),
        .i_reg_offset      (i_reg_offset),
        .i_write_data      (i_write_data),
        .o_rd_byte         (o_rd_byte),
        .o_new_mode_active (o_new_mode_active)
    );

endmodule

### tb/tb_top.sv
module tb_top;
    import fdmr_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_WORDS   = 1900;
    localparam int BACKPRESSURE_HOLD = 64;

    // Offsets that set or clear one latch bit; the first three move it toward register six.
    localparam logic [3:0] LATCH_B7_SET = 4'd15;
    localparam logic [3:0] LATCH_B6_SET = 4'd13;
    localparam logic [3:0] LATCH_B4_CLR = 4'd8;
    localparam logic [3:0] LATCH_B0_SET = 4'd1;
    localparam logic [3:0] LATCH_B4_SET = 4'd9;
    localparam logic [3:0] LATCH_B7_CLR = 4'd14;
    localparam logic [3:0] LATCH_B6_CLR = 4'd12;
    localparam logic [3:0] OFF_UNUSED   = 4'd5;
    localparam logic [3:0] OFF_ZERO     = 4'd0;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    typedef struct packed {
        logic [7:0] rd_byte;
        logic       new_mode;
    } t_access_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic       i_action;
    logic [3:0] i_reg_offset;
    logic [7:0] i_write_data;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_rd_byte;
    logic       o_new_mode_active;

    floppy_ctrl_dual_mode_registers_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_action         (i_action),
        .i_reg_offset     (i_reg_offset),
        .i_write_data     (i_write_data),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_rd_byte        (o_rd_byte),
        .o_new_mode_active(o_new_mode_active)
    );

    always #4 i_clk = ~i_clk;

    // Mirror of the register window, updated as each word is accepted.
    logic                   mirror_new_mode = 1'b0;
    t_switch_step           mirror_step     = SW_WAIT_ONE_A;
    logic [7:0]             mirror_latch    = '0;
    logic [7:0]             mirror_phase    = '0;
    logic [7:0]             mirror_mode     = '0;
    logic [7:0]             mirror_params [PARAM_DEPTH];
    logic [PARAM_IDX_W-1:0] mirror_param_idx = '0;

    t_access_result expected_bus_results[$];
    int fail_count  = 0;
    int words_sent  = 0;
    int stall_cycles = 0;
    int feed_gap_max = 13;
    int sink_idle_max = 13;
    int sink_hold = 0;

    logic [3:0] keep_sel_offsets [11] = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6,
                                          4'd7, 4'd8, 4'd10, 4'd11};

    initial begin
        for (int k = 0; k < PARAM_DEPTH; k++) begin
            mirror_params[k] = '0;
        end
    end

    function automatic t_access_result predict_register_access(input logic is_wr,
                                                               input logic [3:0] off,
                                                               input logic [7:0] data);
        t_access_result res;
        logic [2:0] sel;
        logic one;
        res.rd_byte = '0;
        one = data[MODE_BIT];
        if (!mirror_new_mode) begin
            mirror_latch[off[3:1]] = off[0];
            sel = {mirror_latch[7], mirror_latch[6], mirror_latch[4]};
            if (!is_wr) begin
                res.rd_byte = (sel == LEG_SEL_ALL_ONES) ? ALL_ONES_VALUE : 8'h00;
            end else if (sel == LEG_SEL_SET_MODE) begin
                // A mismatching bit leaves the sequence where it was.
                case (mirror_step)
                    SW_WAIT_ONE_A: if (one) mirror_step = SW_WAIT_ZERO;
                    SW_WAIT_ZERO:  if (!one) mirror_step = SW_WAIT_ONE_B;
                    SW_WAIT_ONE_B: if (one) mirror_step = SW_WAIT_ONE_C;
                    default: begin
                        if (one) begin
                            mirror_new_mode = 1'b1;
                            mirror_mode     = mirror_mode | MODE_BIT_MASK;
                            mirror_step     = SW_WAIT_ONE_A;
                        end
                    end
                endcase
            end
        end else if (is_wr) begin
            case (off)
                OFF_PARAM_WR: begin
                    mirror_params[mirror_param_idx] = data;
                    mirror_param_idx = mirror_param_idx + 1'b1;
                end
                OFF_PHASE_WR: mirror_phase = data;
                OFF_MODE0: begin
                    mirror_mode      = mirror_mode & ~data;
                    mirror_param_idx = '0;
                    if (!mirror_mode[MODE_BIT]) begin
                        mirror_new_mode = 1'b0;
                        mirror_latch    = '0;
                    end
                end
                OFF_MODE1: mirror_mode = mirror_mode | data;
                default: ;
            endcase
        end else begin
            case (off)
                OFF_PARAM_RD: begin
                    res.rd_byte      = mirror_params[mirror_param_idx];
                    mirror_param_idx = mirror_param_idx + 1'b1;
                end
                OFF_PHASE_RD: res.rd_byte = mirror_phase;
                OFF_STATUS:   res.rd_byte = MODE_BIT_MASK;
                OFF_SENSE:    res.rd_byte = (mirror_phase == SENSE_PHASE) ? SENSE_ANSWER : 8'h00;
                default: ;
            endcase
        end
        res.new_mode = mirror_new_mode;
        return res;
    endfunction

    task automatic send_access(input logic is_wr, input logic [3:0] off, input logic [7:0] data);
        int gap;
        gap = $urandom_range(0, feed_gap_max);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_action     <= is_wr;
        i_reg_offset <= off;
        i_write_data <= data;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_bus_results.push_back(predict_register_access(is_wr, off, data));
        words_sent++;
    endtask

    task automatic send_random_word();
        send_access(1'($urandom), 4'($urandom), 8'($urandom));
    endtask

    // The sender stops offering until every result has been taken.
    task automatic wait_results_drained();
        i_valid <= 1'b0;
        while (expected_bus_results.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic enter_new_mode();
        logic [7:0] d;
        logic want_one;
        int tries;
        tries = 0;
        send_access(ACT_READ, LATCH_B6_SET, 8'($urandom));
        send_access(ACT_READ, LATCH_B4_CLR, 8'($urandom));
        send_access(ACT_READ, LATCH_B7_SET, 8'($urandom));
        while (!mirror_new_mode && tries < 16) begin
            want_one = (mirror_step != SW_WAIT_ZERO);
            if ($urandom_range(0, 7) == 0) begin
                want_one = !want_one;
            end
            d = 8'($urandom);
            d[MODE_BIT] = want_one;
            send_access(ACT_WRITE, keep_sel_offsets[$urandom_range(0, 10)], d);
            tries++;
        end
    endtask

    task automatic exercise_new_mode(input int count);
        logic [7:0] d;
        for (int n = 0; n < count && mirror_new_mode; n++) begin
            d = 8'($urandom);
            case ($urandom_range(0, 9))
                0: send_access(ACT_WRITE, OFF_PARAM_WR, d);
                1: send_access(ACT_READ, OFF_PARAM_RD, d);
                2: send_access(ACT_WRITE, OFF_PHASE_WR,
                               ($urandom_range(0, 2) == 0) ? SENSE_PHASE : d);
                3: send_access(ACT_READ, OFF_PHASE_RD, d);
                4: send_access(ACT_READ, OFF_SENSE, d);
                5: send_access(ACT_READ, OFF_STATUS, d);
                6: send_access(ACT_WRITE, OFF_MODE1, d);
                7: begin
                    d[MODE_BIT] = 1'b0;
                    send_access(ACT_WRITE, OFF_MODE0, d);
                end
                default: send_random_word();
            endcase
        end
    endtask

    task automatic leave_new_mode();
        logic [7:0] d;
        if (mirror_new_mode) begin
            d = 8'($urandom);
            d[MODE_BIT] = 1'b1;
            send_access(ACT_WRITE, OFF_MODE0, d);
        end
    endtask

    task automatic pick_idle_profile();
        int choice [3] = '{0, 3, 13};
        feed_gap_max  = choice[$urandom_range(0, 2)];
        sink_idle_max = choice[$urandom_range(0, 2)];
    endtask

    task automatic test_legacy_latches();
        // Set bits 0, 4, 6 and 7, then clear the select bits back to register zero.
        send_access(ACT_READ, LATCH_B0_SET, 8'h00);
        send_access(ACT_READ, LATCH_B4_SET, 8'hff);
        send_access(ACT_READ, LATCH_B6_SET, 8'h00);
        send_access(ACT_WRITE, LATCH_B7_SET, 8'h00);
        send_access(ACT_READ, LATCH_B7_CLR, 8'hff);
        send_access(ACT_READ, LATCH_B6_CLR, 8'h00);
        send_access(ACT_READ, LATCH_B4_CLR, 8'h00);
    endtask

    task automatic test_mode_switch();
        send_access(ACT_READ, LATCH_B6_SET, 8'h00);
        send_access(ACT_WRITE, LATCH_B7_SET, 8'hff);
        // A repeated one while waiting for zero must not advance the sequence.
        send_access(ACT_WRITE, LATCH_B7_SET, 8'hff);
        send_access(ACT_WRITE, LATCH_B7_SET, 8'h00);
        send_access(ACT_WRITE, LATCH_B7_SET, MODE_BIT_MASK);
        send_access(ACT_WRITE, LATCH_B7_SET, MODE_BIT_MASK);
    endtask

    task automatic test_new_mode_registers();
        send_access(ACT_WRITE, OFF_PARAM_WR, 8'h00);
        send_access(ACT_WRITE, OFF_PARAM_WR, 8'hff);
        send_access(ACT_WRITE, OFF_PHASE_WR, SENSE_PHASE);
        send_access(ACT_READ, OFF_SENSE, 8'h00);
        send_access(ACT_READ, OFF_STATUS, 8'hff);
        send_access(ACT_READ, OFF_PHASE_RD, 8'h00);
        send_access(ACT_WRITE, OFF_MODE1, 8'hff);
        send_access(ACT_WRITE, OFF_MODE0, 8'hbf);
        send_access(ACT_READ, OFF_PARAM_RD, 8'h00);
        send_access(ACT_READ, OFF_PARAM_RD, 8'h00);
        send_access(ACT_WRITE, OFF_UNUSED, 8'h12);
        send_access(ACT_READ, OFF_ZERO, 8'hff);
        send_access(ACT_WRITE, OFF_MODE0, MODE_BIT_MASK);
        wait_results_drained();
    endtask

    task automatic test_backpressure();
        feed_gap_max = 0;
        sink_hold    = BACKPRESSURE_HOLD;
        enter_new_mode();
        exercise_new_mode(12);
        leave_new_mode();
        wait_results_drained();
    endtask

    task automatic test_random_traffic();
        int target;
        target = words_sent + RANDOM_WORDS;
        while (words_sent < target) begin
            pick_idle_profile();
            repeat ($urandom_range(0, 6)) send_random_word();
            enter_new_mode();
            exercise_new_mode($urandom_range(4, 40));
            leave_new_mode();
            if ($urandom_range(0, 15) == 0) begin
                wait_results_drained();
            end
        end
        wait_results_drained();
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_action     <= 1'b0;
        i_reg_offset <= '0;
        i_write_data <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_legacy_latches();
        test_mode_switch();
        test_new_mode_registers();
        test_backpressure();
        test_random_traffic();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS floppy_ctrl_dual_mode_registers_top");
        end else begin
            $display("FAIL floppy_ctrl_dual_mode_registers_top");
        end
        $finish;
    end

    initial begin : result_sink
        int idle;
        i_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            idle = $urandom_range(0, sink_idle_max) + sink_hold;
            sink_hold = 0;
            if (idle > 0) begin
                i_ready <= 1'b0;
                repeat (idle) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_access_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_bus_results.size() == 0) begin
                $error("unexpected result: rd_byte %02h new_mode_active %0b",
                       o_rd_byte, o_new_mode_active);
                fail_count++;
            end else begin
                want = expected_bus_results.pop_front();
                if (o_rd_byte !== want.rd_byte) begin
                    $error("rd_byte: expected %02h, got %02h", want.rd_byte, o_rd_byte);
                    fail_count++;
                end
                if (o_new_mode_active !== want.new_mode) begin
                    $error("new_mode_active: expected %0b, got %0b",
                           want.new_mode, o_new_mode_active);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL floppy_ctrl_dual_mode_registers_top");
                $finish;
            end
        end
    end

endmodule

### files.f
sv/fdmr_pkg.sv
sv/fdmr_ctrl.sv
sv/fdmr_dp.sv
sv/floppy_ctrl_dual_mode_registers_top.sv
tb/tb_top.sv
